// ----- rtl/owbm_pkg.sv -----
// owbm_pkg: shared types and constants of the 1-wire bus master.
// Used by every module under rtl; depends on nothing.
`default_nettype none

package owbm_pkg;

    localparam int BITS_PER_BYTE = 8;
    localparam int COUNT_WIDTH   = 12;
    localparam int BIT_IDX_W     = 4;

    // command queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // configuration port
    localparam int ADDR_W    = 5;
    localparam int CFG_IDX_W = 3;
    localparam int DATA_W    = 32;

    localparam logic [CFG_IDX_W-1:0] REG_RESET_LOW     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RESET_RELEASE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SHORT_LOW     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SLOT          = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_WAIT   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_READ_RECOVERY = 3'd5;

    localparam logic [COUNT_WIDTH-1:0] RESET_LOW_DEFAULT     = 12'd500;
    localparam logic [COUNT_WIDTH-1:0] RESET_RELEASE_DEFAULT = 12'd500;
    localparam logic [COUNT_WIDTH-1:0] SHORT_LOW_DEFAULT     = 12'd2;
    localparam logic [COUNT_WIDTH-1:0] SLOT_DEFAULT          = 12'd60;
    localparam logic [COUNT_WIDTH-1:0] SAMPLE_WAIT_DEFAULT   = 12'd2;
    localparam logic [COUNT_WIDTH-1:0] READ_RECOVERY_DEFAULT = 12'd50;

    localparam logic [1:0] MODE_NONE  = 2'd0;
    localparam logic [1:0] MODE_RESET = 2'd1;
    localparam logic [1:0] MODE_WRITE = 2'd2;
    localparam logic [1:0] MODE_READ  = 2'd3;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] write_byte;
        logic       line_level;
    } in_item_t;

    typedef struct packed {
        logic       drive_low;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_byte;
    } out_item_t;

    // decoded tick as it sits in the queue
    typedef struct packed {
        logic       is_rst;
        logic       is_wr;
        logic       is_rd;
        logic [7:0] wbyte;
        logic       line;
    } cmd_t;

    typedef struct packed {
        logic [COUNT_WIDTH-1:0] reset_low_len;
        logic [COUNT_WIDTH-1:0] reset_release_len;
        logic [COUNT_WIDTH-1:0] short_low_len;
        logic [COUNT_WIDTH-1:0] slot_len;
        logic [COUNT_WIDTH-1:0] sample_wait_len;
        logic [COUNT_WIDTH-1:0] read_recovery_len;
    } cfg_t;

endpackage

`default_nettype wire

// ----- rtl/one_wire_bus_master.sv -----
// one_wire_bus_master: top level of the 1-wire bus master timing engine.
// Instantiates owbm_regs, owbm_front, owbm_queue and owbm_engine; uses owbm_pkg.
//
// Usage: each transfer on the s_ channel is one time tick carrying a command
// mode (none, reset, write byte, read byte), the byte to write and the sampled
// line level. Every tick returns exactly one result on the m_ channel: bus drive,
// busy, a one-tick done flag and the last byte read. Mode is honored only on a
// tick where no command is running.
// Path: a transfer is written into the command queue, then popped by the engine,
// whose output register holds the result that becomes valid. Throughput: one tick
// per clock while m_ready is high, set by the phase/counter update in the engine.
// Stalls: when m_ready is low the result holds in the output register and the
// two-entry command queue absorbs further ticks; s_ready drops once it is full.
// Reset (aresetn low, synchronous): queue and output emptied, engine idle, read
// byte cleared, timing registers back to defaults (500, 500, 2, 60, 2, 50).
// Timing registers sit on the APB port at byte addresses 4*i; pready is always
// high and they should be written only while the bus is idle.
`default_nettype none

module one_wire_bus_master (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire owbm_pkg::in_item_t           s_data,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output owbm_pkg::out_item_t               m_data,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [owbm_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [owbm_pkg::DATA_W-1:0]  pwdata,
    output logic      [owbm_pkg::DATA_W-1:0]  prdata,
    output logic                              pready
);

    owbm_pkg::cfg_t cfg;
    owbm_pkg::cmd_t push_cmd;
    owbm_pkg::cmd_t head_cmd;
    logic           push;
    logic           pop;
    logic           q_full;
    logic           q_not_empty;

    owbm_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    owbm_front u_front (
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_full  (q_full),
        .q_push  (push),
        .q_cmd   (push_cmd)
    );

    owbm_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_cmd  (push_cmd),
        .pop       (pop),
        .head_cmd  (head_cmd),
        .full      (q_full),
        .not_empty (q_not_empty)
    );

    owbm_engine u_engine (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg),
        .q_not_empty (q_not_empty),
        .q_head      (head_cmd),
        .q_pop       (pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

endmodule

`default_nettype wire

// ----- rtl/owbm_regs.sv -----
// owbm_regs: APB-style configuration registers holding the slot timing lengths.
// Depends on owbm_pkg.
`default_nettype none

module owbm_regs (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [owbm_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [owbm_pkg::DATA_W-1:0]   pwdata,
    output logic      [owbm_pkg::DATA_W-1:0]   prdata,
    output logic                               pready,
    output owbm_pkg::cfg_t                     cfg
);

    owbm_pkg::cfg_t                   cfg_reg;
    logic [owbm_pkg::CFG_IDX_W-1:0]   idx;
    logic [owbm_pkg::COUNT_WIDTH-1:0] wval;
    logic [owbm_pkg::COUNT_WIDTH-1:0] rval;
    logic                             wr_en;

    assign idx    = paddr[owbm_pkg::ADDR_W-1:2];
    assign wval   = pwdata[owbm_pkg::COUNT_WIDTH-1:0];
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.reset_low_len     <= owbm_pkg::RESET_LOW_DEFAULT;
            cfg_reg.reset_release_len <= owbm_pkg::RESET_RELEASE_DEFAULT;
            cfg_reg.short_low_len     <= owbm_pkg::SHORT_LOW_DEFAULT;
            cfg_reg.slot_len          <= owbm_pkg::SLOT_DEFAULT;
            cfg_reg.sample_wait_len   <= owbm_pkg::SAMPLE_WAIT_DEFAULT;
            cfg_reg.read_recovery_len <= owbm_pkg::READ_RECOVERY_DEFAULT;
        end else if (wr_en) begin
            case (idx)
                owbm_pkg::REG_RESET_LOW:     cfg_reg.reset_low_len     <= wval;
                owbm_pkg::REG_RESET_RELEASE: cfg_reg.reset_release_len <= wval;
                owbm_pkg::REG_SHORT_LOW:     cfg_reg.short_low_len     <= wval;
                owbm_pkg::REG_SLOT:          cfg_reg.slot_len          <= wval;
                owbm_pkg::REG_SAMPLE_WAIT:   cfg_reg.sample_wait_len   <= wval;
                owbm_pkg::REG_READ_RECOVERY: cfg_reg.read_recovery_len <= wval;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            owbm_pkg::REG_RESET_LOW:     rval = cfg_reg.reset_low_len;
            owbm_pkg::REG_RESET_RELEASE: rval = cfg_reg.reset_release_len;
            owbm_pkg::REG_SHORT_LOW:     rval = cfg_reg.short_low_len;
            owbm_pkg::REG_SLOT:          rval = cfg_reg.slot_len;
            owbm_pkg::REG_SAMPLE_WAIT:   rval = cfg_reg.sample_wait_len;
            owbm_pkg::REG_READ_RECOVERY: rval = cfg_reg.read_recovery_len;
            default:                     rval = '0;
        endcase
    end

    assign prdata = {{(owbm_pkg::DATA_W-owbm_pkg::COUNT_WIDTH){1'b0}}, rval};
    assign cfg    = cfg_reg;

endmodule

`default_nettype wire

// ----- rtl/owbm_front.sv -----
// owbm_front: input side; takes tick transfers and decodes the command mode.
// Depends on owbm_pkg.
`default_nettype none

module owbm_front (
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire owbm_pkg::in_item_t s_data,
    input  wire logic               q_full,
    output logic                    q_push,
    output owbm_pkg::cmd_t          q_cmd
);

    assign s_ready = !q_full;
    assign q_push  = s_valid && !q_full;

    always_comb begin
        q_cmd.is_rst = 1'b0;
        q_cmd.is_wr  = 1'b0;
        q_cmd.is_rd  = 1'b0;
        q_cmd.wbyte  = s_data.write_byte;
        q_cmd.line   = s_data.line_level;
        case (s_data.mode)
            owbm_pkg::MODE_RESET: q_cmd.is_rst = 1'b1;
            owbm_pkg::MODE_WRITE: q_cmd.is_wr  = 1'b1;
            owbm_pkg::MODE_READ:  q_cmd.is_rd  = 1'b1;
            default: ;
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/owbm_queue.sv -----
// owbm_queue: short command queue between the front and the timing engine.
// Depends on owbm_pkg.
`default_nettype none

module owbm_queue (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           push,
    input  wire owbm_pkg::cmd_t push_cmd,
    input  wire logic           pop,
    output owbm_pkg::cmd_t      head_cmd,
    output logic                full,
    output logic                not_empty
);

    owbm_pkg::cmd_t                mem_reg [owbm_pkg::QUEUE_DEPTH];
    logic [owbm_pkg::QPTR_W-1:0]   wr_ptr_reg;
    logic [owbm_pkg::QPTR_W-1:0]   rd_ptr_reg;
    logic [owbm_pkg::QPTR_W:0]     count_reg;
    logic [owbm_pkg::QPTR_W:0]     count_next;

    assign full      = (count_reg == (owbm_pkg::QPTR_W+1)'(owbm_pkg::QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head_cmd  = mem_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        full |-> !push) else $error("queue push while full");
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> not_empty) else $error("queue pop while empty");
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= (owbm_pkg::QPTR_W+1)'(owbm_pkg::QUEUE_DEPTH))
        else $error("queue count out of range");
`endif

endmodule

`default_nettype wire

// ----- rtl/owbm_engine.sv -----
// owbm_engine: back end; slot timing state machine, one tick per queue entry,
// with an output register toward the result channel. Depends on owbm_pkg.
`default_nettype none

module owbm_engine (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire owbm_pkg::cfg_t cfg,
    input  wire logic           q_not_empty,
    input  wire owbm_pkg::cmd_t q_head,
    output logic                q_pop,
    output logic                m_valid,
    input  wire logic           m_ready,
    output owbm_pkg::out_item_t m_data
);

    localparam logic [3:0] PH_IDLE    = 4'd0;
    localparam logic [3:0] PH_RST_LOW = 4'd1;
    localparam logic [3:0] PH_RST_REL = 4'd2;
    localparam logic [3:0] PH_W1_LOW  = 4'd3;
    localparam logic [3:0] PH_W1_REL  = 4'd4;
    localparam logic [3:0] PH_W0_LOW  = 4'd5;
    localparam logic [3:0] PH_R_LOW   = 4'd6;
    localparam logic [3:0] PH_R_WAIT  = 4'd7;
    localparam logic [3:0] PH_R_REC   = 4'd8;

    localparam int CW = owbm_pkg::COUNT_WIDTH;
    localparam int BW = owbm_pkg::BIT_IDX_W;
    localparam logic [BW-1:0] LAST_BIT = BW'(owbm_pkg::BITS_PER_BYTE);

    logic [3:0]    phase_reg, phase_next, phase_cur;
    logic [CW-1:0] tick_reg, tick_next, tick_cur;
    logic [BW-1:0] bit_reg, bit_next, bit_cur, bit_inc;
    logic [7:0]    shift_reg, shift_next, shift_cur;
    logic [7:0]    last_reg, last_next;
    logic [CW-1:0] len;
    logic [CW:0]   n;
    logic          drive, busy, done;

    logic                 out_valid_reg;
    owbm_pkg::out_item_t  out_reg;

    assign q_pop   = q_not_empty && (!out_valid_reg || m_ready);
    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    always_comb begin
        phase_cur = phase_reg;
        tick_cur  = tick_reg;
        bit_cur   = bit_reg;
        shift_cur = shift_reg;
        // commands start only from idle; that tick is the first of the new phase
        if (phase_reg == PH_IDLE && (q_head.is_rst || q_head.is_wr || q_head.is_rd)) begin
            tick_cur = '0;
            bit_cur  = '0;
            if (q_head.is_rst) begin
                phase_cur = PH_RST_LOW;
            end else if (q_head.is_wr) begin
                shift_cur = q_head.wbyte;
                phase_cur = q_head.wbyte[0] ? PH_W1_LOW : PH_W0_LOW;
            end else begin
                shift_cur = '0;
                phase_cur = PH_R_LOW;
            end
        end

        phase_next = phase_cur;
        tick_next  = tick_cur;
        bit_next   = bit_cur;
        shift_next = shift_cur;
        last_next  = last_reg;
        drive      = 1'b0;
        busy       = 1'b0;
        done       = 1'b0;
        len        = CW'(1);
        bit_inc    = bit_cur + 1'b1;
        n          = {1'b0, tick_cur} + 1'b1;

        if (phase_cur != PH_IDLE) begin
            busy = 1'b1;
            case (phase_cur)
                PH_RST_LOW: begin drive = 1'b1; len = cfg.reset_low_len; end
                PH_RST_REL: len = cfg.reset_release_len;
                PH_W1_LOW:  begin drive = 1'b1; len = cfg.short_low_len; end
                PH_W1_REL:  len = cfg.slot_len;
                PH_W0_LOW:  begin drive = 1'b1; len = cfg.slot_len; end
                PH_R_LOW:   begin drive = 1'b1; len = cfg.short_low_len; end
                PH_R_WAIT:  len = cfg.sample_wait_len;
                PH_R_REC:   len = cfg.read_recovery_len;
                default:    len = CW'(1);
            endcase

            if (n < {1'b0, len}) begin
                tick_next = n[CW-1:0];
            end else begin
                tick_next = '0;
                case (phase_cur)
                    PH_RST_LOW: phase_next = PH_RST_REL;
                    PH_W1_LOW:  phase_next = PH_W1_REL;
                    PH_W1_REL, PH_W0_LOW: begin
                        shift_next = {1'b0, shift_cur[7:1]};
                        bit_next   = bit_inc;
                        if (bit_inc >= LAST_BIT) begin
                            phase_next = PH_IDLE;
                            done       = 1'b1;
                        end else begin
                            phase_next = shift_cur[1] ? PH_W1_LOW : PH_W0_LOW;
                        end
                    end
                    PH_R_LOW:   phase_next = PH_R_WAIT;
                    PH_R_WAIT: begin
                        shift_next = {q_head.line, shift_cur[7:1]};
                        phase_next = PH_R_REC;
                    end
                    PH_R_REC: begin
                        bit_next = bit_inc;
                        if (bit_inc >= LAST_BIT) begin
                            last_next  = shift_cur;
                            phase_next = PH_IDLE;
                            done       = 1'b1;
                        end else begin
                            phase_next = PH_R_LOW;
                        end
                    end
                    // reset release end, and any stray code
                    default: begin
                        phase_next = PH_IDLE;
                        done       = 1'b1;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_IDLE;
            tick_reg      <= '0;
            bit_reg       <= '0;
            shift_reg     <= '0;
            last_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (q_pop) begin
                phase_reg     <= phase_next;
                tick_reg      <= tick_next;
                bit_reg       <= bit_next;
                shift_reg     <= shift_next;
                last_reg      <= last_next;
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            out_reg.drive_low <= drive;
            out_reg.busy_res  <= busy;
            out_reg.done_res  <= done;
            out_reg.read_byte <= last_next;
        end
    end

`ifndef SYNTHESIS
    a_done_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_reg.done_res |-> out_reg.busy_res)
        else $error("done without busy");
    a_drive_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_reg.drive_low |-> out_reg.busy_res)
        else $error("bus driven while idle");
    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop && done |=> phase_reg == PH_IDLE)
        else $error("engine not idle after done");
    a_bit_range: assert property (@(posedge aclk) disable iff (!aresetn)
        bit_reg <= LAST_BIT) else $error("bit index out of range");
`endif

endmodule

`default_nettype wire
